// ===== rtl/gmt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// gmt_pkg
// Shared constants for the glyph metric table.
// -----------------------------------------------------------------------------
package gmt_pkg;

  localparam int unsigned TableDepthDef = 1024;
  localparam int unsigned AtlasBitsDef  = 12;

  localparam int unsigned CodeW  = 21;
  localparam int unsigned RecW   = 64;
  localparam int unsigned PrintN = 95;
  localparam int unsigned PrintW = 7;

  localparam logic [CodeW-1:0] PrintLo       = 21'd32;
  localparam logic [CodeW-1:0] PrintHi       = 21'd127;
  localparam logic [CodeW-1:0] UncertainCode = 21'h002BD1;
  localparam logic [CodeW-1:0] QuestionCode  = 21'd63;

  localparam logic [2:0] StFound     = 3'd0;
  localparam logic [2:0] StUncertain = 3'd1;
  localparam logic [2:0] StQuestion  = 3'd2;
  localparam logic [2:0] StUnloaded  = 3'd3;
  localparam logic [2:0] StInserted  = 3'd4;
  localparam logic [2:0] StFull      = 3'd5;
  localparam logic [2:0] StRejected  = 3'd6;

  localparam logic OpInsert = 1'b0;
  localparam logic OpLookup = 1'b1;

endpackage
`default_nettype wire

// ===== rtl/glyph_metric_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// glyph_metric_table
// Glyph metric store: printable bank plus sorted table with binary search.
//
// Input channel (in_valid_i/in_ready_o) takes one insert or lookup
// transaction; the output channel (out_valid_o/out_ready_i) returns exactly
// one result per transaction. One transaction is in work at a time.
// A printable insert writes the bank in S_PRD; a printable lookup passes
// S_PRD, S_PWAIT and S_PDONE. A table lookup runs a binary search over the
// one-read-port table RAM, about log2(count)+1 probes, up to two searches on
// a miss (primary, then the uncertainty glyph).
// A table insert runs one search, then shifts the tail up one entry at a time
// (read in S_SHRD, then write in S_SHWR) and writes the new entry in its place.
// The result waits in the output register while the receiver stalls; no new
// transaction is taken until it is delivered.
// Reset clears the state, the entry count and the printable valid bits only;
// the table RAMs need no clearing pass.
// -----------------------------------------------------------------------------
module glyph_metric_table #(
  parameter int unsigned TableDepth     = gmt_pkg::TableDepthDef,
  parameter int unsigned AtlasCoordBits = gmt_pkg::AtlasBitsDef
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire         operation_i,
  input  wire [20:0]  code_point_i,
  input  wire [11:0]  atlas_x_i,
  input  wire [11:0]  atlas_y_i,
  input  wire [7:0]   glyph_width_i,
  input  wire [7:0]   glyph_height_i,
  input  wire signed [7:0] offset_x_i,
  input  wire signed [7:0] offset_y_i,
  input  wire signed [7:0] advance_x_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [2:0]  status_o,
  output logic [20:0] found_code_o,
  output logic [11:0] out_atlas_x_o,
  output logic [11:0] out_atlas_y_o,
  output logic [7:0]  out_width_o,
  output logic [7:0]  out_height_o,
  output logic signed [7:0] out_offset_x_o,
  output logic signed [7:0] out_offset_y_o,
  output logic signed [7:0] out_advance_o
);

  localparam int unsigned AW = $clog2(TableDepth);
  localparam int unsigned CW = $clog2(TableDepth + 1);
  localparam int unsigned CodeW = gmt_pkg::CodeW;
  localparam int unsigned RecW = gmt_pkg::RecW;
  localparam int unsigned EW = CodeW + RecW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PRD   = 4'd1;
  localparam logic [3:0] S_PWAIT = 4'd2;
  localparam logic [3:0] S_PDONE = 4'd3;
  localparam logic [3:0] S_BSTEP = 4'd4;
  localparam logic [3:0] S_BWAIT = 4'd5;
  localparam logic [3:0] S_BCMP  = 4'd6;
  localparam logic [3:0] S_FINAL = 4'd7;
  localparam logic [3:0] S_FWAIT = 4'd8;
  localparam logic [3:0] S_FCHK  = 4'd9;
  localparam logic [3:0] S_SHRD  = 4'd10;
  localparam logic [3:0] S_SHWR  = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0] state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] lo_q, lo_d, hi_q, hi_d, sh_q, sh_d;
  logic [gmt_pkg::PrintN-1:0] pvalid_q, pvalid_d;
  logic op_q;
  logic [CodeW-1:0] code_q, key_q, key_d;
  logic [RecW-1:0] rec_q;
  logic [2:0] st_q, st_d;
  logic [CodeW-1:0] oc_q, oc_d;
  logic [RecW-1:0] orec_q, orec_d;
  logic fb_q, fb_d;
  logic op_d;
  logic [CodeW-1:0] code_d;
  logic [RecW-1:0] rec_d;

  // printable bank
  logic p_we;
  logic [gmt_pkg::PrintW-1:0] p_waddr, p_raddr;
  logic [RecW-1:0] p_rdata;
  // table
  logic t_we;
  logic [AW-1:0] t_waddr, t_raddr;
  logic [EW-1:0] t_wdata, t_rdata;
  logic [CW-1:0] mid;
  logic [CodeW-1:0] t_code;
  logic [RecW-1:0] in_rec;
  logic [AtlasCoordBits-1:0] amask;

  assign amask = '1;
  always_comb begin
    in_rec = {atlas_x_i & 12'(amask), atlas_y_i & 12'(amask), glyph_width_i,
              glyph_height_i, offset_x_i, offset_y_i, advance_x_i};
  end

  gmt_ram #(.Width(RecW), .Depth(gmt_pkg::PrintN)) u_print (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(rec_q),
    .raddr_i(p_raddr), .rdata_o(p_rdata));

  gmt_ram #(.Width(EW), .Depth(TableDepth)) u_table (
    .clk_i, .we_i(t_we), .waddr_i(t_waddr), .wdata_i(t_wdata),
    .raddr_i(t_raddr), .rdata_o(t_rdata));

  assign t_code = t_rdata[EW-1:RecW];
  assign mid = lo_q + ((hi_q - lo_q) >> 1);
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign status_o = st_q;
  assign found_code_o = oc_q;
  assign {out_atlas_x_o, out_atlas_y_o, out_width_o, out_height_o,
          out_offset_x_o, out_offset_y_o, out_advance_o} = orec_q;

  always_comb begin
    state_d = state_q; count_d = count_q; lo_d = lo_q; hi_d = hi_q; sh_d = sh_q;
    pvalid_d = pvalid_q; key_d = key_q; st_d = st_q; oc_d = oc_q; orec_d = orec_q;
    fb_d = fb_q; op_d = op_q; code_d = code_q; rec_d = rec_q;
    p_we = 1'b0;
    p_waddr = gmt_pkg::PrintW'(code_q - gmt_pkg::PrintLo);
    p_raddr = gmt_pkg::PrintW'(key_q - gmt_pkg::PrintLo);
    t_we = 1'b0;
    t_waddr = sh_q[AW-1:0];
    t_wdata = t_rdata;
    t_raddr = mid[AW-1:0];
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d = operation_i; code_d = code_point_i; rec_d = in_rec;
          key_d = code_point_i; fb_d = 1'b0;
          lo_d = '0; hi_d = count_q;
          oc_d = code_point_i; orec_d = '0;
          if (code_point_i >= gmt_pkg::PrintLo && code_point_i < gmt_pkg::PrintHi) begin
            state_d = S_PRD;
          end else if (operation_i == gmt_pkg::OpInsert) begin
            if (code_point_i < gmt_pkg::PrintLo) begin
              st_d = gmt_pkg::StRejected; state_d = S_OUT;
            end else if (count_q >= CW'(TableDepth)) begin
              st_d = gmt_pkg::StFull; state_d = S_OUT;
            end else begin
              state_d = S_BSTEP;
            end
          end else begin
            state_d = S_BSTEP;
          end
        end
      end
      S_PRD: begin
        if (op_q == gmt_pkg::OpInsert) begin
          p_we = 1'b1;
          pvalid_d[p_waddr] = 1'b1;
          st_d = gmt_pkg::StInserted; state_d = S_OUT;
        end else begin
          state_d = S_PWAIT;
        end
      end
      S_PWAIT: state_d = S_PDONE;
      S_PDONE: begin
        oc_d = key_q;
        if (pvalid_q[p_raddr]) begin
          orec_d = p_rdata;
          st_d = fb_q ? gmt_pkg::StQuestion : gmt_pkg::StFound;
        end else begin
          orec_d = '0; st_d = gmt_pkg::StUnloaded;
        end
        state_d = S_OUT;
      end
      S_BSTEP: begin
        if (lo_q < hi_q) state_d = S_BWAIT;
        else begin
          t_raddr = lo_q[AW-1:0];
          state_d = S_FINAL;
        end
      end
      S_BWAIT: state_d = S_BCMP;
      S_BCMP: begin
        if (t_code < key_q) lo_d = mid + CW'(1);
        else hi_d = mid;
        state_d = S_BSTEP;
      end
      S_FINAL: begin
        t_raddr = lo_q[AW-1:0];
        state_d = S_FWAIT;
      end
      S_FWAIT: begin
        t_raddr = lo_q[AW-1:0];
        state_d = S_FCHK;
      end
      S_FCHK: begin
        if (op_q == gmt_pkg::OpInsert) begin
          sh_d = count_q;
          state_d = S_SHRD;
        end else if (lo_q < count_q && t_code == key_q) begin
          orec_d = t_rdata[RecW-1:0]; oc_d = key_q;
          st_d = (key_q == code_q) ? gmt_pkg::StFound : gmt_pkg::StUncertain;
          state_d = S_OUT;
        end else if (key_q == code_q && code_q != gmt_pkg::UncertainCode) begin
          key_d = gmt_pkg::UncertainCode; lo_d = '0; hi_d = count_q;
          state_d = S_BSTEP;
        end else begin
          key_d = gmt_pkg::QuestionCode; fb_d = 1'b1;
          state_d = S_PWAIT;
        end
      end
      S_SHRD: begin
        // read entry sh-1 for move to sh
        t_raddr = AW'(sh_q - CW'(1));
        if (sh_q == lo_q) begin
          t_we = 1'b1;
          t_wdata = {code_q, rec_q};
          count_d = count_q + CW'(1);
          st_d = gmt_pkg::StInserted; state_d = S_OUT;
        end else begin
          state_d = S_SHWR;
        end
      end
      S_SHWR: begin
        t_we = 1'b1;
        sh_d = sh_q - CW'(1);
        state_d = S_SHRD;
      end
      S_OUT: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      pvalid_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pvalid_q <= pvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d; hi_q <= hi_d; sh_q <= sh_d; key_q <= key_d;
    st_q <= st_d; oc_q <= oc_d; orec_q <= orec_d; fb_q <= fb_d;
    op_q <= op_d; code_q <= code_d; rec_q <= rec_d;
  end

endmodule
`default_nettype wire

// ===== rtl/gmt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// gmt_ram
// Generic single-port-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module gmt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(Depth)-1:0] waddr_i,
  input  wire [Width-1:0]         wdata_i,
  input  wire [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]        rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb
// Self-checking testbench for glyph_metric_table.
// Drives insert and lookup transactions with random gaps and output stalls,
// predicts every result from a local copy of the printable bank and sorted
// table, and checks results in order. A directed start covers rejection,
// substitution, duplicates and unloaded slots; a random body follows; the
// table is then filled to capacity to exercise the full status.
// -----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic [11:0]       ax;
    logic [11:0]       ay;
    logic [7:0]        w;
    logic [7:0]        h;
    logic signed [7:0] ox;
    logic signed [7:0] oy;
    logic signed [7:0] adv;
  } glyph_rec_t;

  typedef struct {
    logic                      op;
    logic [gmt_pkg::CodeW-1:0] code;
    glyph_rec_t                rec;
  } glyph_req_t;

  typedef struct {
    logic [2:0]                status;
    logic [gmt_pkg::CodeW-1:0] code;
    glyph_rec_t                rec;
  } glyph_res_t;

  class glyph_scoreboard;
    glyph_rec_t                bank[gmt_pkg::PrintN];
    bit                        bank_ok[gmt_pkg::PrintN];
    logic [gmt_pkg::CodeW-1:0] keys[$];
    glyph_rec_t                vals[$];
    glyph_res_t                waiting[$];
    int                        errors;
    int                        checked;
    int                        status_seen[8];

    function int search_pos(logic [gmt_pkg::CodeW-1:0] c);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = keys.size();
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (keys[mid] < c) lo = mid + 1;
        else hi = mid;
      end
      return lo;
    endfunction

    function bit find(logic [gmt_pkg::CodeW-1:0] c, output glyph_rec_t r);
      int i;
      i = search_pos(c);
      r = '{default: '0};
      if (i < keys.size() && keys[i] == c) begin
        r = vals[i];
        return 1;
      end
      return 0;
    endfunction

    function void note_input(glyph_req_t t);
      glyph_res_t e;
      glyph_rec_t r;
      int         idx;
      int         pos;
      e.status = gmt_pkg::StFound;
      e.code   = t.code;
      e.rec    = '{default: '0};
      idx      = int'(t.code) - int'(gmt_pkg::PrintLo);
      if (t.op == gmt_pkg::OpInsert) begin
        if (t.code < gmt_pkg::PrintLo) begin
          e.status = gmt_pkg::StRejected;
        end else if (t.code < gmt_pkg::PrintHi) begin
          bank[idx] = t.rec;
          bank_ok[idx] = 1;
          e.status = gmt_pkg::StInserted;
        end else if (keys.size() >= gmt_pkg::TableDepthDef) begin
          e.status = gmt_pkg::StFull;
        end else begin
          pos = search_pos(t.code);
          keys.insert(pos, t.code);
          vals.insert(pos, t.rec);
          e.status = gmt_pkg::StInserted;
        end
      end else if (t.code >= gmt_pkg::PrintLo && t.code < gmt_pkg::PrintHi) begin
        if (bank_ok[idx]) e.rec = bank[idx];
        else e.status = gmt_pkg::StUnloaded;
      end else if (find(t.code, r)) begin
        e.rec = r;
      end else if (t.code != gmt_pkg::UncertainCode && find(gmt_pkg::UncertainCode, r)) begin
        e.status = gmt_pkg::StUncertain;
        e.code   = gmt_pkg::UncertainCode;
        e.rec    = r;
      end else begin
        e.code = gmt_pkg::QuestionCode;
        idx = int'(gmt_pkg::QuestionCode) - int'(gmt_pkg::PrintLo);
        if (bank_ok[idx]) begin
          e.status = gmt_pkg::StQuestion;
          e.rec    = bank[idx];
        end else begin
          e.status = gmt_pkg::StUnloaded;
        end
      end
      waiting.push_back(e);
    endfunction

    function void check_result(glyph_res_t got);
      glyph_res_t e;
      if (waiting.size() == 0) begin
        errors++;
        $display("%0t: unexpected result status %0d code %h", $time, got.status, got.code);
        return;
      end
      e = waiting.pop_front();
      checked++;
      status_seen[got.status]++;
      if (got.status !== e.status) begin
        errors++;
        $display("%0t: status exp %0d got %0d", $time, e.status, got.status);
      end
      if (got.code !== e.code) begin
        errors++;
        $display("%0t: found_code exp %h got %h", $time, e.code, got.code);
      end
      if (got.rec !== e.rec) begin
        errors++;
        $display("%0t: record exp %p got %p", $time, e.rec, got.rec);
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              operation_i;
  logic [20:0]       code_point_i;
  logic [11:0]       atlas_x_i;
  logic [11:0]       atlas_y_i;
  logic [7:0]        glyph_width_i;
  logic [7:0]        glyph_height_i;
  logic signed [7:0] offset_x_i;
  logic signed [7:0] offset_y_i;
  logic signed [7:0] advance_x_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [2:0]        status_o;
  logic [20:0]       found_code_o;
  logic [11:0]       out_atlas_x_o;
  logic [11:0]       out_atlas_y_o;
  logic [7:0]        out_width_o;
  logic [7:0]        out_height_o;
  logic signed [7:0] out_offset_x_o;
  logic signed [7:0] out_offset_y_o;
  logic signed [7:0] out_advance_o;

  glyph_metric_table dut (.*);

  glyph_scoreboard glyphs;
  int              send_idle;
  int              recv_idle;
  int              hold_req;
  int              sent;
  int              fill_code;

  initial begin
    clk_i = 0;
  end
  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  function automatic glyph_rec_t rand_rec();
    glyph_rec_t r;
    r.ax  = 12'($urandom);
    r.ay  = 12'($urandom);
    r.w   = 8'($urandom);
    r.h   = 8'($urandom);
    r.ox  = 8'($urandom);
    r.oy  = 8'($urandom);
    r.adv = 8'($urandom);
    return r;
  endfunction

  function automatic glyph_req_t rand_req();
    glyph_req_t t;
    int         sel;
    sel   = $urandom_range(99);
    t.op  = 1'($urandom_range(1));
    t.rec = rand_rec();
    if (sel < 8) t.code = 21'($urandom_range(31));
    else if (sel < 35) t.code = 21'($urandom_range(126, 32));
    else if (sel < 40) t.code = gmt_pkg::UncertainCode;
    else if (sel < 88) t.code = 21'($urandom_range(400, 127));
    else if (sel < 98) t.code = 21'($urandom_range(21'h1FEFFF, 0));
    else t.code = 21'h1FFFFF;
    return t;
  endfunction

  function automatic glyph_req_t mk(logic op, logic [20:0] c, glyph_rec_t r);
    glyph_req_t t;
    t.op   = op;
    t.code = c;
    t.rec  = r;
    return t;
  endfunction

  task automatic send(glyph_req_t t);
    if ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= t.op;
    code_point_i   <= t.code;
    atlas_x_i      <= t.rec.ax;
    atlas_y_i      <= t.rec.ay;
    glyph_width_i  <= t.rec.w;
    glyph_height_i <= t.rec.h;
    offset_x_i     <= t.rec.ox;
    offset_y_i     <= t.rec.oy;
    advance_x_i    <= t.rec.adv;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    glyphs.note_input(t);
    sent++;
  endtask

  initial begin
    int hold;
    glyph_res_t got;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got.status  = status_o;
        got.code    = found_code_o;
        got.rec.ax  = out_atlas_x_o;
        got.rec.ay  = out_atlas_y_o;
        got.rec.w   = out_width_o;
        got.rec.h   = out_height_o;
        got.rec.ox  = out_offset_x_o;
        got.rec.oy  = out_offset_y_o;
        got.rec.adv = out_advance_o;
        glyphs.check_result(got);
      end
      if (hold_req > 0) begin
        hold = hold_req;
        hold_req = 0;
      end
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin
    #200000000;
    $display("glyph_metric_table test failed");
    $finish;
  end

  initial begin
    glyph_rec_t zr;
    glyph_rec_t mr;
    int         n;
    glyphs         = new();
    zr             = '{default: '0};
    mr             = '{12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'sh7F, 8'sh7F, 8'sh7F};
    send_idle      = 28;
    recv_idle      = 72;
    hold_req       = 0;
    sent           = 0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    out_ready_i    = 1'b0;
    operation_i    = 1'b0;
    code_point_i   = '0;
    atlas_x_i      = '0;
    atlas_y_i      = '0;
    glyph_width_i  = '0;
    glyph_height_i = '0;
    offset_x_i     = '0;
    offset_y_i     = '0;
    advance_x_i    = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(mk(gmt_pkg::OpLookup, 21'd65, zr));
    send(mk(gmt_pkg::OpLookup, 21'd5, zr));
    send(mk(gmt_pkg::OpInsert, 21'd0, mr));
    send(mk(gmt_pkg::OpInsert, 21'd31, mr));
    send(mk(gmt_pkg::OpLookup, gmt_pkg::QuestionCode, zr));
    send(mk(gmt_pkg::OpInsert, 21'd32, mr));
    send(mk(gmt_pkg::OpInsert, 21'd126, zr));
    send(mk(gmt_pkg::OpLookup, 21'd32, zr));
    send(mk(gmt_pkg::OpLookup, 21'd126, zr));
    send(mk(gmt_pkg::OpInsert, gmt_pkg::QuestionCode, rand_rec()));
    send(mk(gmt_pkg::OpInsert, 21'd127, mr));
    send(mk(gmt_pkg::OpLookup, 21'd127, zr));
    send(mk(gmt_pkg::OpLookup, 21'd200, zr));
    send(mk(gmt_pkg::OpLookup, gmt_pkg::UncertainCode, zr));
    send(mk(gmt_pkg::OpInsert, gmt_pkg::UncertainCode, rand_rec()));
    send(mk(gmt_pkg::OpLookup, 21'd200, zr));
    send(mk(gmt_pkg::OpLookup, gmt_pkg::UncertainCode, zr));
    send(mk(gmt_pkg::OpInsert, 21'd127, zr));
    send(mk(gmt_pkg::OpLookup, 21'd127, zr));
    send(mk(gmt_pkg::OpInsert, 21'd32, rand_rec()));
    send(mk(gmt_pkg::OpLookup, 21'd32, zr));
    send(mk(gmt_pkg::OpLookup, 21'h1FFFFF, zr));
    send(mk(gmt_pkg::OpInsert, 21'h1FFFFF, mr));
    send(mk(gmt_pkg::OpLookup, 21'h1FFFFF, zr));
    send(mk(gmt_pkg::OpLookup, 21'd0, zr));

    repeat (420) send(rand_req());
    send_idle = 72;
    recv_idle = 28;
    hold_req  = 300;
    repeat (420) send(rand_req());
    send_idle = 0;
    recv_idle = 0;
    repeat (420) send(rand_req());

    // ascending keys land near the tail, so filling costs few shifts
    fill_code = 21'h1FF000;
    while (glyphs.keys.size() < gmt_pkg::TableDepthDef) begin
      send(mk(gmt_pkg::OpInsert, fill_code[20:0], rand_rec()));
      fill_code++;
    end
    send(mk(gmt_pkg::OpInsert, 21'd300, rand_rec()));
    send(mk(gmt_pkg::OpInsert, 21'h1FFFFF, rand_rec()));
    send(mk(gmt_pkg::OpInsert, 21'd40, rand_rec()));
    send(mk(gmt_pkg::OpLookup, 21'h1FF000, zr));
    send(mk(gmt_pkg::OpLookup, fill_code[20:0] - 21'd1, zr));
    in_valid_i <= 1'b0;

    n = 0;
    while (glyphs.waiting.size() != 0 && n < 100000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (100) @(posedge clk_i);
    $display("%0d transactions, %0d results checked, table held %0d entries",
             sent, glyphs.checked, glyphs.keys.size());
    $display("status counts found/unc/quest/unloaded/ins/full/rej: %0d %0d %0d %0d %0d %0d %0d",
             glyphs.status_seen[gmt_pkg::StFound], glyphs.status_seen[gmt_pkg::StUncertain],
             glyphs.status_seen[gmt_pkg::StQuestion], glyphs.status_seen[gmt_pkg::StUnloaded],
             glyphs.status_seen[gmt_pkg::StInserted], glyphs.status_seen[gmt_pkg::StFull],
             glyphs.status_seen[gmt_pkg::StRejected]);
    if (glyphs.errors == 0 && glyphs.waiting.size() == 0) begin
      $display("glyph_metric_table test passed");
    end else begin
      $display("glyph_metric_table test failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/gmt_pkg.sv
rtl/gmt_ram.sv
rtl/glyph_metric_table.sv
tb/tb.sv
